/* src/drct_pkg.sv */
// Shared constants, codes and types of the datagram relay client table.
package drct_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int SOCK_W      = 16;
    localparam int HOST_W      = 32;
    localparam int PORT_W      = 16;
    localparam int ACT_W       = 2;
    localparam int SLOT_OUT_W  = 4;

    localparam int S_TDATA_W   = 160;
    localparam int M_FIELDS_W  = SLOT_OUT_W + HOST_W + PORT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SOCK_W-1:0] REG_SOCKET = 16'h0002;
    localparam logic [HOST_W-1:0] REG_HOST   = 32'h0000_0000;
    localparam logic [HOST_W-1:0] BCAST_HOST = 32'hffff_ffff;

    localparam logic [ACT_W-1:0] ACT_NEW       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RECONNECT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORWARD   = 2'd2;

    typedef struct packed {
        logic              is_reg;
        logic              is_bcast;
        logic [HOST_W-1:0] dest_host;
        logic [PORT_W-1:0] dest_port;
        logic [HOST_W-1:0] src_host;
        logic [PORT_W-1:0] src_port;
        logic [HOST_W-1:0] sender_host;
        logic [PORT_W-1:0] sender_port;
    } hdr_t;

endpackage

/* src/drct_front.sv */
// Front end: header intake, classification and a short header queue.
module drct_front
    import drct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 q_valid,
    output hdr_t                 q_head,
    input  logic                 q_pop
);

    hdr_t              fifo_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    hdr_t              in_hdr;
    logic              push;
    logic              pop;
    logic [SOCK_W-1:0] in_socket;

    assign in_socket          = s_tdata[15:0];
    assign in_hdr.dest_host   = s_tdata[47:16];
    assign in_hdr.dest_port   = s_tdata[63:48];
    assign in_hdr.src_host    = s_tdata[95:64];
    assign in_hdr.src_port    = s_tdata[111:96];
    assign in_hdr.sender_host = s_tdata[143:112];
    assign in_hdr.sender_port = s_tdata[159:144];
    assign in_hdr.is_reg      = (in_socket == REG_SOCKET) && (in_hdr.dest_host == REG_HOST);
    assign in_hdr.is_bcast    = (in_hdr.dest_host == BCAST_HOST);

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_head   = fifo_mem_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= in_hdr;
        end
    end

endmodule

/* src/drct_back.sv */
// Back end: client table, slot scan sequencer and result output register.
module drct_back
    import drct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  hdr_t                 q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [ACT_W-1:0]     m_tuser,
    output logic                 m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REG   = 2'd1;
    localparam logic [1:0] ST_FWD   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [HOST_W-1:0]     pend_host_reg, pend_host_next;
    logic [PORT_W-1:0]     pend_port_reg, pend_port_next;

    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [HOST_W-1:0]      host_mem_reg [TABLE_SLOTS];
    logic [PORT_W-1:0]      port_mem_reg [TABLE_SLOTS];

    logic                  m_tvalid_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [HOST_W-1:0]     out_host_reg;
    logic [PORT_W-1:0]     out_port_reg;
    logic [ACT_W-1:0]      out_act_reg;
    logic                  out_last_reg;

    logic [1:0]            mode;
    logic                  busy, out_free, step;
    logic                  cur_valid;
    logic [HOST_W-1:0]     cur_host;
    logic [PORT_W-1:0]     cur_port;
    logic                  src_match, dst_match, hit, last_idx;

    logic                  emit, emit_last;
    logic [ACT_W-1:0]      emit_act;
    logic [SLOT_W-1:0]     emit_slot;
    logic [HOST_W-1:0]     emit_host;
    logic [PORT_W-1:0]     emit_port;
    logic                  tbl_new, tbl_port;

    assign mode      = (state_reg == ST_IDLE) ? (q_head.is_reg ? ST_REG : ST_FWD) : state_reg;
    assign busy      = (state_reg != ST_IDLE) || q_valid;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign step      = busy && out_free;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_host  = host_mem_reg[idx_reg];
    assign cur_port  = port_mem_reg[idx_reg];
    assign src_match = (cur_host == q_head.src_host) && (cur_port == q_head.src_port);
    assign dst_match = (cur_host == q_head.dest_host) && (cur_port == q_head.dest_port);
    assign hit       = cur_valid && (q_head.is_bcast ? !src_match : dst_match)
                       && (n_reg != CNT_W'(MAX_RESULTS));
    assign last_idx  = (idx_reg == SLOT_W'(TABLE_SLOTS - 1));

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_host_next  = pend_host_reg;
        pend_port_next  = pend_port_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        emit_act        = ACT_FORWARD;
        emit_slot       = idx_reg;
        emit_host       = q_head.sender_host;
        emit_port       = q_head.sender_port;
        tbl_new         = 1'b0;
        tbl_port        = 1'b0;
        q_pop           = 1'b0;
        if (step) begin
            case (mode)
                ST_REG: begin
                    if (!cur_valid) begin
                        tbl_new    = 1'b1;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_act   = ACT_NEW;
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else if (src_match) begin
                        tbl_port   = 1'b1;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_act   = ACT_RECONNECT;
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else if (last_idx) begin
                        // table full: fall through to forwarding
                        state_next = ST_FWD;
                        idx_next   = '0;
                    end else begin
                        state_next = ST_REG;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
                ST_FWD: begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            emit      = 1'b1;
                            emit_act  = ACT_FORWARD;
                            emit_slot = pend_slot_reg;
                            emit_host = pend_host_reg;
                            emit_port = pend_port_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        pend_host_next  = cur_host;
                        pend_port_next  = cur_port;
                        n_next          = n_reg + 1'b1;
                    end
                    if (last_idx) begin
                        state_next = ST_FLUSH;
                        idx_next   = '0;
                    end else begin
                        state_next = ST_FWD;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    if (pend_valid_reg) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_act  = ACT_FORWARD;
                        emit_slot = pend_slot_reg;
                        emit_host = pend_host_reg;
                        emit_port = pend_port_reg;
                    end
                    pend_valid_next = 1'b0;
                    n_next          = '0;
                    q_pop           = 1'b1;
                    state_next      = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            if (tbl_new) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        pend_host_reg <= pend_host_next;
        pend_port_reg <= pend_port_next;
        if (tbl_new) begin
            host_mem_reg[idx_reg] <= q_head.sender_host;
        end
        if (tbl_new || tbl_port) begin
            port_mem_reg[idx_reg] <= q_head.sender_port;
        end
        if (emit) begin
            out_act_reg  <= emit_act;
            out_slot_reg <= SLOT_OUT_W'(emit_slot);
            out_host_reg <= emit_host;
            out_port_reg <= emit_port;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_port_reg, out_host_reg, out_slot_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* src/datagram_relay_client_table_top.sv */
// Top level of the datagram relay client table.
//
// s_ channel: one received tunnel header per word. m_ channel: one
// acknowledge or forward copy per word, m_tlast on the final word of a
// header, m_tuser carrying the action code.
// Headers enter a two-deep queue; the back end visits one table slot per
// cycle while no word waits on m_tready. A registration that decides
// at slot k visits slots 0 to k and gives one word. A forwarded header
// visits all 16 slots, then a flush step releases the held copy with
// m_tlast; a registration that finds the table full scans it once more
// to forward. The slot scan is the limit on throughput; the queue lets
// the next header in meanwhile.
// Reset empties the table and the queue and drops any word on m_.
// While a word waits on m_tready it holds and the scan halts; the
// queue keeps taking headers until it is full.
module datagram_relay_client_table_top
    import drct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dest_socket, dest_host, dest_port, src_host, src_port, sender_host, sender_port
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot, target_host, target_port, zero padding
    output logic [M_TDATA_W-1:0] m_tdata,
    // action
    output logic [ACT_W-1:0]     m_tuser,
    output logic                 m_tlast
);

    logic q_valid;
    hdr_t q_head;
    logic q_pop;

    drct_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    drct_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/drct_checker.sv */
// Port-level checks on the client table, bound to the top level.
module drct_checker
    import drct_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [ACT_W-1:0]     m_tuser,
    input logic                 m_tlast
);

    // acknowledges are always the single word of their header
    a_ack_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_NEW || m_tuser == ACT_RECONNECT) |-> m_tlast)
        else $error("acknowledge without tlast");

    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ACT_NEW || m_tuser == ACT_RECONNECT
                      || m_tuser == ACT_FORWARD))
        else $error("undefined action code");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind datagram_relay_client_table_top drct_checker u_drct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* test/tb_datagram_relay_client_table_top.sv */
// Testbench for the datagram relay client table: predicted acknowledges and copies vs m_ words.
`timescale 1ns / 100ps

module tb_datagram_relay_client_table_top;
    import drct_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RAND_HDRS   = 70;
    localparam int QUIET_FROM  = 56;

    // dest_socket, the first header field, in the lowest bits
    typedef struct packed {
        logic [PORT_W-1:0] sender_port;
        logic [HOST_W-1:0] sender_host;
        logic [PORT_W-1:0] src_port;
        logic [HOST_W-1:0] src_host;
        logic [PORT_W-1:0] dest_port;
        logic [HOST_W-1:0] dest_host;
        logic [SOCK_W-1:0] dest_socket;
    } relay_hdr_t;

    typedef struct {
        logic [ACT_W-1:0]      action;
        logic [SLOT_OUT_W-1:0] slot;
        logic [HOST_W-1:0]     host;
        logic [PORT_W-1:0]     port;
        logic                  last;
    } relay_word_t;

    class relay_scoreboard;
        bit                valid_tab[TABLE_SLOTS];
        logic [HOST_W-1:0] host_tab[TABLE_SLOTS];
        logic [PORT_W-1:0] port_tab[TABLE_SLOTS];
        relay_word_t       due_words[$];
        int                mismatches;

        function void add_word(logic [ACT_W-1:0] act, int idx, logic [HOST_W-1:0] h,
                               logic [PORT_W-1:0] p, logic lst);
            relay_word_t w;
            w.action = act;
            w.slot   = idx[SLOT_OUT_W-1:0];
            w.host   = h;
            w.port   = p;
            w.last   = lst;
            due_words.push_back(w);
        endfunction

        // registration first, then fan-out
        function void note_header(relay_hdr_t hd);
            int  n;
            bit  hit;
            n = 0;
            if (hd.dest_socket == REG_SOCKET && hd.dest_host == REG_HOST) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!valid_tab[i]) begin
                        valid_tab[i] = 1'b1;
                        host_tab[i]  = hd.sender_host;
                        port_tab[i]  = hd.sender_port;
                        add_word(ACT_NEW, i, hd.sender_host, hd.sender_port, 1'b1);
                        return;
                    end
                    if (host_tab[i] == hd.src_host && port_tab[i] == hd.src_port) begin
                        port_tab[i] = hd.sender_port;
                        add_word(ACT_RECONNECT, i, hd.sender_host, hd.sender_port, 1'b1);
                        return;
                    end
                end
            end
            for (int i = 0; i < TABLE_SLOTS && n < MAX_RESULTS; i++) begin
                if (valid_tab[i]) begin
                    if (hd.dest_host == BCAST_HOST)
                        hit = host_tab[i] != hd.src_host || port_tab[i] != hd.src_port;
                    else
                        hit = host_tab[i] == hd.dest_host && port_tab[i] == hd.dest_port;
                    if (hit) begin
                        add_word(ACT_FORWARD, i, host_tab[i], port_tab[i], 1'b0);
                        n++;
                    end
                end
            end
            if (n > 0)
                due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        function void check_word(relay_word_t got);
            relay_word_t want;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: act=%0d slot=%0d host=%h port=%h last=%b",
                             got.action, got.slot, got.host, got.port, got.last);
                return;
            end
            want = due_words.pop_front();
            if (got.action !== want.action || got.slot !== want.slot ||
                got.host !== want.host || got.port !== want.port || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: want act=%0d slot=%0d host=%h port=%h last=%b",
                             want.action, want.slot, want.host, want.port, want.last);
                    $display("          got  act=%0d slot=%0d host=%h port=%h last=%b",
                             got.action, got.slot, got.host, got.port, got.last);
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ACT_W-1:0]     m_tuser;
    logic                 m_tlast;

    relay_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              stall_left = 0;
    int              cycles = 0;

    datagram_relay_client_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_datagram_relay_client_table_top: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        relay_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.action = m_tuser;
            got.slot   = m_tdata[SLOT_OUT_W-1:0];
            got.host   = m_tdata[SLOT_OUT_W +: HOST_W];
            got.port   = m_tdata[SLOT_OUT_W+HOST_W +: PORT_W];
            got.last   = m_tlast;
            sb.check_word(got);
        end
    end

    function automatic relay_hdr_t mk_hdr(logic [SOCK_W-1:0] sock, logic [HOST_W-1:0] dh,
                                          logic [PORT_W-1:0] dp, logic [HOST_W-1:0] sh,
                                          logic [PORT_W-1:0] sp, logic [HOST_W-1:0] rh,
                                          logic [PORT_W-1:0] rp);
        relay_hdr_t hd;
        hd.dest_socket = sock;
        hd.dest_host   = dh;
        hd.dest_port   = dp;
        hd.src_host    = sh;
        hd.src_port    = sp;
        hd.sender_host = rh;
        hd.sender_port = rp;
        return hd;
    endfunction

    task automatic offer_header(relay_hdr_t hd);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hd;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_header(hd);
    endtask

    function automatic logic [SOCK_W-1:0] rand_socket();
        return ($urandom_range(0, 1) == 0) ? REG_SOCKET : SOCK_W'($urandom);
    endfunction

    initial begin
        relay_hdr_t hd;
        int         k;
        int         sel;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: no receiver, unicast and broadcast
        offer_header(mk_hdr(16'h0000, 32'h1234_5678, 16'h4321, 32'h0, 16'h0, 32'h1, 16'h1));
        offer_header(mk_hdr(16'hffff, BCAST_HOST, 16'hffff, 32'h5, 16'h5, 32'h6, 16'h6));
        // new clients, extremes of sender address
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h0, 32'h77, 16'h77,
                            32'h0a00_0001, 16'h1000));
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'hffff, 32'h78, 16'h78,
                            32'hffff_ffff, 16'hffff));
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h1, 32'h79, 16'h79,
                            32'h0000_0000, 16'h0000));
        // reconnect on slot 0, port moves to 0x2000
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h0, 32'h0a00_0001, 16'h1000,
                            32'h0a00_00ff, 16'h2000));
        offer_header(mk_hdr(16'h0000, 32'h0a00_0001, 16'h2000, 32'h9, 16'h9, 32'h9, 16'h9));
        // broadcast from a member skips it
        offer_header(mk_hdr(16'h0002, BCAST_HOST, 16'h0, 32'hffff_ffff, 16'hffff,
                            32'h3, 16'h3));
        // registration socket but nonzero host is plain traffic
        offer_header(mk_hdr(REG_SOCKET, 32'h0a00_0001, 16'h2000, 32'h1, 16'h1, 32'h2, 16'h2));
        // zero host on another socket reaches the zero-address client
        offer_header(mk_hdr(16'hffff, 32'h0, 16'h0, 32'h1, 16'h1, 32'h2, 16'h2));
        // duplicate address in a second slot gives two copies
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h0, 32'hdead, 16'hbeef,
                            32'h0a00_0001, 16'h2000));
        offer_header(mk_hdr(16'h0001, 32'h0a00_0001, 16'h2000, 32'h0, 16'h0, 32'h0, 16'h0));
        for (int i = 0; i < TABLE_SLOTS - 4; i++)
            offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h0, 32'hdead, 16'hbeef,
                                HOST_W'(32'hc0a8_0000 | (i % 3)),
                                PORT_W'(16'h3000 + (i % 4))));
        // full table: registration falls through to unicast on host 0 port 0
        offer_header(mk_hdr(REG_SOCKET, REG_HOST, 16'h0, 32'hdead, 16'hbeef,
                            32'h4, 16'h4));
        // broadcast from outside the table reaches every slot
        offer_header(mk_hdr(16'h0000, BCAST_HOST, 16'h0, 32'hdead, 16'hbeef, 32'h4, 16'h4));

        for (int n = 0; n < RAND_HDRS; n++) begin
            quiet = n >= QUIET_FROM;
            k   = $urandom_range(0, TABLE_SLOTS - 1);
            sel = $urandom_range(0, 9);
            hd  = {$urandom, $urandom, $urandom, $urandom, $urandom};
            case (sel)
                0, 1, 2: begin
                    hd.dest_socket = REG_SOCKET;
                    hd.dest_host   = REG_HOST;
                    if (sel != 2) begin
                        hd.src_host = sb.host_tab[k];
                        hd.src_port = sb.port_tab[k];
                    end
                    if ($urandom_range(0, 1) == 0)
                        hd.sender_port = sb.port_tab[$urandom_range(0, TABLE_SLOTS - 1)];
                end
                3, 4: begin
                    hd.dest_socket = rand_socket();
                    hd.dest_host   = sb.host_tab[k];
                    hd.dest_port   = sb.port_tab[k];
                end
                5, 6: begin
                    hd.dest_socket = rand_socket();
                    hd.dest_host   = BCAST_HOST;
                    if (sel == 5) begin
                        hd.src_host = sb.host_tab[k];
                        hd.src_port = sb.port_tab[k];
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        hd.dest_socket = REG_SOCKET;
                end
            endcase
            offer_header(hd);
        end
        s_tvalid <= 1'b0;

        while (sb.due_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.mismatches == 0 && sb.due_words.size() == 0)
            $display("tb_datagram_relay_client_table_top: clean");
        else
            $display("tb_datagram_relay_client_table_top: errors");
        $finish;
    end

endmodule

/* files.f */
src/drct_pkg.sv
src/drct_front.sv
src/drct_back.sv
src/datagram_relay_client_table_top.sv
src/drct_checker.sv
test/tb_datagram_relay_client_table_top.sv
